FILE: rtl/led_matrix_grayscale_scanner_defines.svh
// ============================================================================
// LED matrix grayscale scanner - assertion macros
// Shared concurrent assertion forms for the scanner modules.
// ============================================================================
`ifndef LED_MATRIX_GRAYSCALE_SCANNER_DEFINES_SVH
`define LED_MATRIX_GRAYSCALE_SCANNER_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define LMGS_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define LMGS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define LMGS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lmgs_pkg.sv
// ============================================================================
// lmgs_pkg
// Types, constants and command/status structs for the LED matrix scanner.
// ============================================================================
package lmgs_pkg;

    // Frame geometry
    localparam int ROWS_DEF = 8;
    localparam int NCHAN    = 24;
    localparam int NPAIRS   = 12;

    // Field widths
    localparam int ACT_W  = 3;
    localparam int ROW_W  = 3;
    localparam int CH_W   = 5;
    localparam int LED_W  = 3;
    localparam int GRAY_W = 12;
    localparam int BYTE_W = 8;
    localparam int CODE_W = 3;
    localparam int PAIR_W = 4;
    localparam int AMAX_W = 8;

    // Actions
    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE     = 3'd0,
        ACT_READ      = 3'd1,
        ACT_SET_LED   = 3'd2,
        ACT_FILL_VAL  = 3'd3,
        ACT_FILL_LEDS = 3'd4,
        ACT_ROT_LEFT  = 3'd5,
        ACT_ROT_RIGHT = 3'd6,
        ACT_REFRESH   = 3'd7
    } t_action;

    // Result kinds
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_STREAM = 1'b1;

    // Row select codes per scan row
    localparam logic [CODE_W-1:0] ROW_CODE [8] = '{
        3'd3, 3'd6, 3'd5, 3'd4, 3'd7, 3'd0, 3'd1, 3'd2
    };

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_REPLY,
        ST_LED_G,
        ST_LED_B,
        ST_FILL,
        ST_RF_RA,
        ST_RF_RB,
        ST_EMIT0,
        ST_EMIT1,
        ST_EMIT2
    } t_state;

    // Memory address source
    typedef enum logic [2:0] {
        ADDR_ITEM,
        ADDR_LED_R,
        ADDR_LED_G,
        ADDR_LED_B,
        ADDR_FILL,
        ADDR_SCAN_A,
        ADDR_SCAN_B
    } t_addr_sel;

    // Memory write data source
    typedef enum logic [2:0] {
        WD_ZERO,
        WD_GRAY,
        WD_RED,
        WD_GREEN,
        WD_BLUE,
        WD_LEDS
    } t_wd_sel;

    // Result register source
    typedef enum logic [1:0] {
        OUT_READ,
        OUT_B0,
        OUT_B1,
        OUT_B2
    } t_out_sel;

    // Controller to datapath
    typedef struct packed {
        logic      load_item;
        logic      mem_we;
        logic      mem_re;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        logic      fill_step;
        logic      latch_a;
        logic      out_load;
        t_out_sel  out_sel;
        logic      pair_step;
        logic      scan_adv;
        logic      rot_left;
        logic      rot_right;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_action action;
        logic    row_ok;
        logic    item_ok;
        logic    fill_last;
        logic    pair_last;
        logic    slot_free;
    } t_sts;

endpackage

FILE: rtl/lmgs_item_if.sv
// ============================================================================
// lmgs_item_if
// Valid/ready channel carrying one scanner action.
// ============================================================================
interface lmgs_item_if;
    logic                           valid;
    logic                           ready;
    logic [lmgs_pkg::ACT_W-1:0]     action;
    logic [lmgs_pkg::ROW_W-1:0]     row;
    logic [lmgs_pkg::CH_W-1:0]      channel;
    logic [lmgs_pkg::LED_W-1:0]     led_index;
    logic [lmgs_pkg::GRAY_W-1:0]    gray_value;
    logic [lmgs_pkg::GRAY_W-1:0]    red_value;
    logic [lmgs_pkg::GRAY_W-1:0]    green_value;
    logic [lmgs_pkg::GRAY_W-1:0]    blue_value;

    modport source (
        output valid, action, row, channel, led_index,
               gray_value, red_value, green_value, blue_value,
        input  ready
    );
    modport sink (
        input  valid, action, row, channel, led_index,
               gray_value, red_value, green_value, blue_value,
        output ready
    );
endinterface

FILE: rtl/lmgs_result_if.sv
// ============================================================================
// lmgs_result_if
// Valid/ready channel carrying one read reply or stream byte.
// ============================================================================
interface lmgs_result_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [lmgs_pkg::GRAY_W-1:0]    read_value;
    logic [lmgs_pkg::BYTE_W-1:0]    stream_byte;
    logic [lmgs_pkg::CODE_W-1:0]    row_code;
    logic                           last;

    modport source (
        output valid, kind, read_value, stream_byte, row_code, last,
        input  ready
    );
    modport sink (
        input  valid, kind, read_value, stream_byte, row_code, last,
        output ready
    );
endinterface

FILE: rtl/lmgs_ram.sv
// ============================================================================
// lmgs_ram
// Single-port RAM, one access per cycle, registered read data.
// ============================================================================
module lmgs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/lmgs_ctrl.sv
// ============================================================================
// lmgs_ctrl
// Sequencer: decodes each action and steps the datapath through it.
// ============================================================================
`include "led_matrix_grayscale_scanner_defines.svh"

module lmgs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lmgs_pkg::t_sts i_sts,
    output lmgs_pkg::t_cmd o_cmd
);
    lmgs_pkg::t_state r_state;
    lmgs_pkg::t_state n_state;

    // state register, reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmgs_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lmgs_pkg::ST_CLEAR: begin
                if (i_sts.fill_last) n_state = lmgs_pkg::ST_IDLE;
            end
            lmgs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lmgs_pkg::ST_DISP;
            end
            lmgs_pkg::ST_DISP: begin
                case (i_sts.action)
                    lmgs_pkg::ACT_READ:      n_state = lmgs_pkg::ST_REPLY;
                    lmgs_pkg::ACT_SET_LED:   n_state = lmgs_pkg::ST_LED_G;
                    lmgs_pkg::ACT_FILL_VAL,
                    lmgs_pkg::ACT_FILL_LEDS: n_state = lmgs_pkg::ST_FILL;
                    lmgs_pkg::ACT_REFRESH:   n_state = lmgs_pkg::ST_RF_RA;
                    default:                 n_state = lmgs_pkg::ST_IDLE;
                endcase
            end
            lmgs_pkg::ST_REPLY: begin
                if (i_sts.slot_free) n_state = lmgs_pkg::ST_IDLE;
            end
            lmgs_pkg::ST_LED_G: n_state = lmgs_pkg::ST_LED_B;
            lmgs_pkg::ST_LED_B: n_state = lmgs_pkg::ST_IDLE;
            lmgs_pkg::ST_FILL: begin
                if (i_sts.fill_last) n_state = lmgs_pkg::ST_IDLE;
            end
            lmgs_pkg::ST_RF_RA: n_state = lmgs_pkg::ST_RF_RB;
            lmgs_pkg::ST_RF_RB: n_state = lmgs_pkg::ST_EMIT0;
            lmgs_pkg::ST_EMIT0: begin
                if (i_sts.slot_free) n_state = lmgs_pkg::ST_EMIT1;
            end
            lmgs_pkg::ST_EMIT1: begin
                if (i_sts.slot_free) n_state = lmgs_pkg::ST_EMIT2;
            end
            lmgs_pkg::ST_EMIT2: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.pair_last ? lmgs_pkg::ST_IDLE : lmgs_pkg::ST_RF_RA;
                end
            end
            default: n_state = lmgs_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = lmgs_pkg::ADDR_ITEM;
        o_cmd.wd_sel   = lmgs_pkg::WD_GRAY;
        o_cmd.out_sel  = lmgs_pkg::OUT_READ;
        o_in_ready     = 1'b0;
        case (r_state)
            lmgs_pkg::ST_CLEAR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.addr_sel  = lmgs_pkg::ADDR_FILL;
                o_cmd.wd_sel    = lmgs_pkg::WD_ZERO;
                o_cmd.fill_step = 1'b1;
            end
            lmgs_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            lmgs_pkg::ST_DISP: begin
                case (i_sts.action)
                    lmgs_pkg::ACT_WRITE: begin
                        o_cmd.mem_we = i_sts.item_ok;
                    end
                    lmgs_pkg::ACT_READ: begin
                        o_cmd.mem_re = 1'b1;
                    end
                    lmgs_pkg::ACT_SET_LED: begin
                        o_cmd.mem_we   = i_sts.row_ok;
                        o_cmd.addr_sel = lmgs_pkg::ADDR_LED_R;
                        o_cmd.wd_sel   = lmgs_pkg::WD_RED;
                    end
                    lmgs_pkg::ACT_ROT_LEFT:  o_cmd.rot_left  = 1'b1;
                    lmgs_pkg::ACT_ROT_RIGHT: o_cmd.rot_right = 1'b1;
                    default: ;
                endcase
            end
            lmgs_pkg::ST_REPLY: begin
                o_cmd.out_load = i_sts.slot_free;
            end
            lmgs_pkg::ST_LED_G: begin
                o_cmd.mem_we   = i_sts.row_ok;
                o_cmd.addr_sel = lmgs_pkg::ADDR_LED_G;
                o_cmd.wd_sel   = lmgs_pkg::WD_GREEN;
            end
            lmgs_pkg::ST_LED_B: begin
                o_cmd.mem_we   = i_sts.row_ok;
                o_cmd.addr_sel = lmgs_pkg::ADDR_LED_B;
                o_cmd.wd_sel   = lmgs_pkg::WD_BLUE;
            end
            lmgs_pkg::ST_FILL: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.addr_sel  = lmgs_pkg::ADDR_FILL;
                o_cmd.wd_sel    = (i_sts.action == lmgs_pkg::ACT_FILL_LEDS) ?
                                  lmgs_pkg::WD_LEDS : lmgs_pkg::WD_GRAY;
                o_cmd.fill_step = 1'b1;
            end
            lmgs_pkg::ST_RF_RA: begin
                o_cmd.mem_re   = 1'b1;
                o_cmd.addr_sel = lmgs_pkg::ADDR_SCAN_A;
            end
            lmgs_pkg::ST_RF_RB: begin
                o_cmd.mem_re   = 1'b1;
                o_cmd.addr_sel = lmgs_pkg::ADDR_SCAN_B;
                o_cmd.latch_a  = 1'b1;
            end
            lmgs_pkg::ST_EMIT0: begin
                o_cmd.out_load = i_sts.slot_free;
                o_cmd.out_sel  = lmgs_pkg::OUT_B0;
            end
            lmgs_pkg::ST_EMIT1: begin
                o_cmd.out_load = i_sts.slot_free;
                o_cmd.out_sel  = lmgs_pkg::OUT_B1;
            end
            lmgs_pkg::ST_EMIT2: begin
                o_cmd.out_load  = i_sts.slot_free;
                o_cmd.out_sel   = lmgs_pkg::OUT_B2;
                o_cmd.pair_step = i_sts.slot_free;
                o_cmd.scan_adv  = i_sts.slot_free && i_sts.pair_last;
            end
            default: ;
        endcase
    end

    // checks
    `LMGS_ASSERT_NEXT(a_row_done_idle, i_clk, i_rst_n,
        r_state == lmgs_pkg::ST_EMIT2 && i_sts.slot_free && i_sts.pair_last,
        r_state == lmgs_pkg::ST_IDLE, "refresh did not end after last pair")
    `LMGS_ASSERT_IMPLY(a_one_mem_op, i_clk, i_rst_n, o_cmd.mem_we, !o_cmd.mem_re,
        "store read and written in one cycle")
endmodule

FILE: rtl/lmgs_dp.sv
// ============================================================================
// lmgs_dp
// Datapath: item register, frame store, row pointers and result register.
// ============================================================================
`include "led_matrix_grayscale_scanner_defines.svh"

module lmgs_dp #(
    parameter int ROWS = lmgs_pkg::ROWS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lmgs_item_if.sink       i_item,
    lmgs_result_if.source   o_result,
    input  lmgs_pkg::t_cmd  i_cmd,
    output lmgs_pkg::t_sts  o_sts
);
    localparam int DEPTH  = ROWS * lmgs_pkg::NCHAN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = lmgs_pkg::ROW_W;
    localparam int CH_W   = lmgs_pkg::CH_W;
    localparam int GW     = lmgs_pkg::GRAY_W;
    localparam int BW     = lmgs_pkg::BYTE_W;

    // latched item
    lmgs_pkg::t_action              r_action;
    logic [ROW_W-1:0]               r_row;
    logic [CH_W-1:0]                r_channel;
    logic [lmgs_pkg::LED_W-1:0]     r_led;
    logic [GW-1:0]                  r_gray;
    logic [GW-1:0]                  r_red;
    logic [GW-1:0]                  r_green;
    logic [GW-1:0]                  r_blue;

    // scan and rotation pointers
    logic [ROW_W-1:0]               r_scan_row;
    logic [ROW_W-1:0]               r_row_offset;
    logic [lmgs_pkg::PAIR_W-1:0]    r_pair;
    logic [ADDR_W-1:0]              r_fill_addr;
    logic [CH_W-1:0]                r_fill_ch;
    logic [GW-1:0]                  r_a;

    // result register
    logic                           r_out_valid;
    logic                           r_kind;
    logic [GW-1:0]                  r_read_value;
    logic [BW-1:0]                  r_byte;
    logic [lmgs_pkg::CODE_W-1:0]    r_code;
    logic                           r_last;

    logic [ADDR_W-1:0]              w_addr;
    logic [GW-1:0]                  w_wdata;
    logic [GW-1:0]                  w_rdata;
    logic [CH_W-1:0]                w_ch_a;
    logic [ROW_W-1:0]               w_item_phys;
    logic [ROW_W-1:0]               w_scan_phys;
    logic                           w_slot_free;
    logic [ROW_W:0]                 w_off_inc;
    logic [ROW_W:0]                 w_scan_inc;

    // logical to physical row through the rotation offset
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] off);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, off};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // row * 24 + channel, by shifts
    function automatic logic [lmgs_pkg::AMAX_W-1:0] entry(input logic [ROW_W-1:0] prow,
                                                          input logic [CH_W-1:0] ch);
        logic [lmgs_pkg::AMAX_W-1:0] wrow;
        wrow = lmgs_pkg::AMAX_W'(prow);
        return (wrow << 4) + (wrow << 3) + lmgs_pkg::AMAX_W'(ch);
    endfunction

    assign w_item_phys = phys_row(r_row, r_row_offset);
    assign w_scan_phys = phys_row(r_scan_row, r_row_offset);
    assign w_ch_a      = CH_W'(lmgs_pkg::NCHAN - 1) - {r_pair, 1'b0};
    assign w_slot_free = !r_out_valid || o_result.ready;
    assign w_off_inc   = {1'b0, r_row_offset} + 1'b1;
    assign w_scan_inc  = {1'b0, r_scan_row} + 1'b1;

    // store address select
    always_comb begin
        case (i_cmd.addr_sel)
            lmgs_pkg::ADDR_ITEM:   w_addr = ADDR_W'(entry(w_item_phys, r_channel));
            lmgs_pkg::ADDR_LED_R:  w_addr = ADDR_W'(entry(w_item_phys, CH_W'(r_led)));
            lmgs_pkg::ADDR_LED_G:  w_addr = ADDR_W'(entry(w_item_phys,
                                       CH_W'(lmgs_pkg::NCHAN - 1) - CH_W'(r_led)));
            lmgs_pkg::ADDR_LED_B:  w_addr = ADDR_W'(entry(w_item_phys,
                                       CH_W'(r_led) + CH_W'(8)));
            lmgs_pkg::ADDR_FILL:   w_addr = r_fill_addr;
            lmgs_pkg::ADDR_SCAN_A: w_addr = ADDR_W'(entry(w_scan_phys, w_ch_a));
            lmgs_pkg::ADDR_SCAN_B: w_addr = ADDR_W'(entry(w_scan_phys, w_ch_a - 1'b1));
            default:               w_addr = r_fill_addr;
        endcase
    end

    // store write data select; LED fill: red 0..7, blue 8..15, green 16..23
    always_comb begin
        case (i_cmd.wd_sel)
            lmgs_pkg::WD_ZERO:  w_wdata = '0;
            lmgs_pkg::WD_GRAY:  w_wdata = r_gray;
            lmgs_pkg::WD_RED:   w_wdata = r_red;
            lmgs_pkg::WD_GREEN: w_wdata = r_green;
            lmgs_pkg::WD_BLUE:  w_wdata = r_blue;
            lmgs_pkg::WD_LEDS: begin
                case (r_fill_ch[4:3])
                    2'd0:    w_wdata = r_red;
                    2'd1:    w_wdata = r_blue;
                    default: w_wdata = r_green;
                endcase
            end
            default: w_wdata = '0;
        endcase
    end

    lmgs_ram #(
        .WIDTH (GW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_re    (i_cmd.mem_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // item register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action  <= lmgs_pkg::t_action'(i_item.action);
            r_row     <= i_item.row;
            r_channel <= i_item.channel;
            r_led     <= i_item.led_index;
            r_gray    <= i_item.gray_value;
            r_red     <= i_item.red_value;
            r_green   <= i_item.green_value;
            r_blue    <= i_item.blue_value;
        end
        if (i_cmd.latch_a) begin
            r_a <= w_rdata;
        end
    end

    // pointers and sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row   <= '0;
            r_row_offset <= '0;
            r_pair       <= '0;
            r_fill_addr  <= '0;
            r_fill_ch    <= '0;
        end else begin
            if (i_cmd.rot_left) begin
                r_row_offset <= (w_off_inc >= (ROW_W+1)'(ROWS)) ? '0 : w_off_inc[ROW_W-1:0];
            end else if (i_cmd.rot_right) begin
                r_row_offset <= (r_row_offset == '0) ? ROW_W'(ROWS - 1) :
                                r_row_offset - 1'b1;
            end
            if (i_cmd.scan_adv) begin
                r_scan_row <= (w_scan_inc >= (ROW_W+1)'(ROWS)) ? '0 : w_scan_inc[ROW_W-1:0];
            end
            if (i_cmd.pair_step) begin
                r_pair <= o_sts.pair_last ? '0 : r_pair + 1'b1;
            end
            if (i_cmd.fill_step) begin
                if (o_sts.fill_last) begin
                    r_fill_addr <= '0;
                    r_fill_ch   <= '0;
                end else begin
                    r_fill_addr <= r_fill_addr + 1'b1;
                    r_fill_ch   <= (r_fill_ch == CH_W'(lmgs_pkg::NCHAN - 1)) ? '0 :
                                   r_fill_ch + 1'b1;
                end
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                lmgs_pkg::OUT_READ: begin
                    r_kind       <= lmgs_pkg::KIND_READ;
                    r_read_value <= o_sts.item_ok ? w_rdata : '0;
                    r_byte       <= '0;
                    r_code       <= '0;
                    r_last       <= 1'b0;
                end
                lmgs_pkg::OUT_B0: begin
                    r_kind       <= lmgs_pkg::KIND_STREAM;
                    r_read_value <= '0;
                    r_byte       <= r_a[GW-1:4];
                    r_code       <= lmgs_pkg::ROW_CODE[r_scan_row];
                    r_last       <= 1'b0;
                end
                lmgs_pkg::OUT_B1: begin
                    r_kind       <= lmgs_pkg::KIND_STREAM;
                    r_read_value <= '0;
                    r_byte       <= {r_a[3:0], w_rdata[GW-1:8]};
                    r_code       <= lmgs_pkg::ROW_CODE[r_scan_row];
                    r_last       <= 1'b0;
                end
                default: begin
                    r_kind       <= lmgs_pkg::KIND_STREAM;
                    r_read_value <= '0;
                    r_byte       <= w_rdata[BW-1:0];
                    r_code       <= lmgs_pkg::ROW_CODE[r_scan_row];
                    r_last       <= o_sts.pair_last;
                end
            endcase
        end
    end

    // status to the controller
    assign o_sts.action    = r_action;
    assign o_sts.row_ok    = ((ROW_W+1)'(r_row) < (ROW_W+1)'(ROWS));
    assign o_sts.item_ok   = o_sts.row_ok && (r_channel < CH_W'(lmgs_pkg::NCHAN));
    assign o_sts.fill_last = (r_fill_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.pair_last = (r_pair == lmgs_pkg::PAIR_W'(lmgs_pkg::NPAIRS - 1));
    assign o_sts.slot_free = w_slot_free;

    // result channel
    assign o_result.valid       = r_out_valid;
    assign o_result.kind        = r_kind;
    assign o_result.read_value  = r_read_value;
    assign o_result.stream_byte = r_byte;
    assign o_result.row_code    = r_code;
    assign o_result.last        = r_last;

    // checks
    `LMGS_ASSERT_IMPLY(a_reply_clean, i_clk, i_rst_n, r_out_valid && r_kind == lmgs_pkg::KIND_READ,
        r_byte == '0 && r_code == '0 && !r_last, "read reply carries stream fields")
    `LMGS_ASSERT_ALWAYS(a_rows_in_range, i_clk, i_rst_n,
        (ROW_W+1)'(r_scan_row) < (ROW_W+1)'(ROWS) &&
        (ROW_W+1)'(r_row_offset) < (ROW_W+1)'(ROWS), "row pointer out of range")
    `LMGS_ASSERT_NEXT(a_scan_moves, i_clk, i_rst_n, i_cmd.scan_adv,
        r_scan_row != $past(r_scan_row), "scan row did not advance")
endmodule

FILE: rtl/led_matrix_grayscale_scanner.sv
// ============================================================================
// led_matrix_grayscale_scanner
// Grayscale frame store and row scanner for a multiplexed LED matrix.
//
// channel   | dir | contents
// ----------+-----+--------------------------------------------------------
// i_item    | in  | action, row, channel, led_index, gray/red/green/blue
// o_result  | out | kind, read_value, stream_byte, row_code, last
//
// Set LED writes the red, green and blue entries in turn. Fills write one
// store entry per cycle through the single RAM port. A refresh does, per
// channel pair, two reads, then 3 bytes. After reset a clearing sweep zeroes
// the store; no item is taken meanwhile. Output stalls hold the sequencer in
// its reply or emit state.
// ============================================================================
module led_matrix_grayscale_scanner #(
    parameter int ROWS = lmgs_pkg::ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lmgs_item_if.sink     i_item,
    lmgs_result_if.source o_result
);
    lmgs_pkg::t_cmd w_cmd;
    lmgs_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_item.ready = w_in_ready;

    lmgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lmgs_dp #(
        .ROWS (ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );
endmodule
